// ===== hw/rtl/bsr_pkg.sv =====
// Shared types and constants for the bounded stack search and remove unit.
// Used by the front queue, the back engine and the top level; no dependencies.
package bsr_pkg;

   localparam int VALUE_W    = 32;
   localparam int TAG_W      = 8;
   localparam int ENTRY_W    = VALUE_W + TAG_W;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;
   localparam int OCC_W      = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - (POS_W + VALUE_W + TAG_W + OCC_W + 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_FIND   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  key;
      logic [TAG_W-1:0]           tag;
   } qent_type;

endpackage

// ===== hw/rtl/bsr_front.sv =====
// Front part: takes request items, decodes the operation and holds them in
// a two-entry queue for the back engine. Depends on bsr_pkg.
module bsr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bsr_pkg::REQ_DATA_W-1:0] req_tdata,  // value_in [31:0], tag_in [39:32]
   input  logic [bsr_pkg::OP_W-1:0]     req_tuser,  // operation [1:0]
   output logic                         q_valid,
   input  logic                         q_ready,
   output bsr_pkg::qent_type            q_entry
);
   import bsr_pkg::*;

   qent_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   qent_type   new_entry;

   assign req_tready = (fill_ff != 2'd2);
   assign q_valid    = (fill_ff != 2'd0);
   assign q_entry    = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      new_entry.op  = op_type'(req_tuser[OP_W-1:0]);
      new_entry.key = req_tdata[VALUE_W-1:0];
      new_entry.tag = req_tdata[VALUE_W +: TAG_W];
      wr_ptr_in     = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in       = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== hw/rtl/bsr_back.sv =====
// Back part: the entry memory, the entry count and the sequencer that carries
// out push, pop, find and remove, plus the response register. Depends on bsr_pkg.
module bsr_back #(
   parameter int DEPTH = 8,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  bsr_pkg::qent_type               q_entry,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [bsr_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic [CW-1:0]                   count
);
   import bsr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_POP   = 6'b000100,
      S_SCAN  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [ENTRY_W-1:0] entry_mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   state_type              state_ff, state_in;
   qent_type               item_ff, item_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in;
   status_type             res_status_ff, res_status_in;
   logic [CW-1:0]          res_pos_ff, res_pos_in;
   logic [VALUE_W-1:0]     res_value_ff, res_value_in;
   logic [TAG_W-1:0]       res_tag_ff, res_tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]    rsp_user_ff, rsp_user_in;

   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [VALUE_W-1:0]     rd_value;
   logic [TAG_W-1:0]       rd_tag;
   logic [CW-1:0]          idx_wide, next_idx, after_next_idx;
   logic [CW+POS_W-1:0]    pos_ext, occ_ext;

   assign rd_value       = rd_data_ff[VALUE_W-1:0];
   assign rd_tag         = rd_data_ff[VALUE_W +: TAG_W];
   assign idx_wide       = CW'(idx_ff);
   assign next_idx       = idx_wide + CW'(1);
   assign after_next_idx = idx_wide + CW'(2);
   assign pos_ext        = {{POS_W{1'b0}}, res_pos_ff};
   assign occ_ext        = {{POS_W{1'b0}}, count_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign count      = count_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_value_in  = res_value_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      q_ready       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_ready       = 1'b1;
               item_in       = q_entry;
               res_status_in = ST_OK;
               res_pos_in    = '0;
               res_value_in  = '0;
               res_tag_in    = '0;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            case (item_ff.op)
               OP_PUSH: begin
                  if (count_ff == DEPTH_C) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(count_ff);
                     wr_data  = {item_ff.tag, item_ff.key};
                     count_in = count_ff + CW'(1);
                  end
                  state_in = S_EMIT;
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     count_in = count_ff - CW'(1);
                     state_in = S_POP;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     idx_in   = AW'(count_ff - CW'(1));
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_POP: begin
            res_value_in = rd_value;
            res_tag_in   = rd_tag;
            state_in     = S_EMIT;
         end
         S_SCAN: begin
            // One entry a cycle from the top; the read for the next slot
            // down is issued while this one is compared.
            if (rd_value == item_ff.key) begin
               res_pos_in   = count_ff - idx_wide;
               res_value_in = rd_value;
               res_tag_in   = rd_tag;
               if (item_ff.op == OP_REMOVE) begin
                  if (next_idx < count_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(next_idx);
                     state_in = S_SHIFT;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = S_EMIT;
                  end
               end else begin
                  state_in = S_EMIT;
               end
            end else if (idx_ff == '0) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - AW'(1);
               idx_in  = idx_ff - AW'(1);
            end
         end
         S_SHIFT: begin
            // The entry above the hole moves down one slot each cycle.
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = AW'(next_idx);
            if (after_next_idx < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = AW'(after_next_idx);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, (count_ff == DEPTH_C), occ_ext[OCC_W-1:0],
                               res_tag_ff, res_value_ff, pos_ext[POS_W-1:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_value_ff  <= res_value_in;
      res_tag_ff    <= res_tag_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/bounded_stack_search_remove_unit.sv =====
// Bounded LIFO stack with search and remove-by-value, top level.
// Items are carried out one at a time: the back engine scans for a find, and scans
// and then shifts for a remove, one entry per cycle; the request queue and the
// response register decouple stalls.
// Reset (synchronous, active high) empties the stack and the queue; entries stay undefined.
module bounded_stack_search_remove_unit #(
   parameter int DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bsr_pkg::REQ_DATA_W-1:0]  req_tdata,  // value_in [31:0], tag_in [39:32]
   input  logic [bsr_pkg::OP_W-1:0]        req_tuser,  // operation [1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // position [3:0], value_out [35:4], tag_out [43:36], occupancy [47:44],
   // is_full [48], zero [55:49]
   output logic [bsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [bsr_pkg::STATUS_W-1:0]    rsp_tuser   // status [1:0]
);
   import bsr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          q_valid, q_ready;
   qent_type      q_entry;
   logic [CW-1:0] count;

   bsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry)
   );

   bsr_back #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .count      (count)
   );

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH))
      else $error("entry count exceeds capacity");

   // The count moves by at most one entry between clock edges.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count != $past(count)) |->
         (count == $past(count) + CW'(1) || count + CW'(1) == $past(count)))
      else $error("entry count jumped by more than one");

   // A rejected push is only reported when the stack is full.
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_FULL) |-> rsp_tdata[48])
      else $error("full status without full flag");

   // A pop on an empty stack reports an empty stack and no position.
   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_EMPTY) |->
         (rsp_tdata[47:44] == 4'd0 && rsp_tdata[3:0] == 4'd0))
      else $error("empty status with entries or a position");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the bounded stack search and remove unit.
// Drives push, pop, find and remove items under random idling and checks every response
// against a behavioural stack held here. Depends on bsr_pkg and the RTL top level only.
module testbench;
   import bsr_pkg::*;

   localparam int DEPTH       = 8;
   localparam int MAX_LATENCY = 2 * DEPTH + 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 370;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
      logic [TAG_W-1:0]   tag;
      logic [OCC_W-1:0]   occupancy;
      logic               is_full;
   } stack_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // value_in [31:0], tag_in [39:32]
   logic [OP_W-1:0] req_tuser = OP_PUSH;   // operation [1:0]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // position [3:0], value_out [35:4], tag_out [43:36], occupancy [47:44],
   // is_full [48], zero [55:49]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;         // status [1:0]

   // Mirror of the stack contents; slot 0 is the bottom.
   logic [VALUE_W-1:0] held_value [DEPTH];
   logic [TAG_W-1:0]   held_tag [DEPTH];
   int                 held_count = 0;

   stack_reply_type awaited_replies [$];
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int checked_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   bounded_stack_search_remove_unit #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Applies one operation to the mirrored stack and returns the response it should give.
   function automatic stack_reply_type apply_stack_op(op_type op, logic [VALUE_W-1:0] key,
                                                     logic [TAG_W-1:0] tag);
      stack_reply_type r;
      int slot;
      r = '0;
      r.status = ST_OK;
      slot = -1;
      case (op)
         OP_PUSH: begin
            if (held_count == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_value[held_count] = key;
               held_tag[held_count] = tag;
               held_count++;
            end
         end
         OP_POP: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               held_count--;
               r.value = held_value[held_count];
               r.tag = held_tag[held_count];
            end
         end
         default: begin
            // The scan runs from the top, so the newest of several equal values wins.
            for (int d = held_count - 1; d >= 0 && slot < 0; d--)
               if (held_value[d] == key) slot = d;
            if (slot < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               r.position = POS_W'(held_count - slot);
               r.value = held_value[slot];
               r.tag = held_tag[slot];
               if (op == OP_REMOVE) begin
                  for (int i = slot; i < held_count - 1; i++) begin
                     held_value[i] = held_value[i + 1];
                     held_tag[i] = held_tag[i + 1];
                  end
                  held_count--;
               end
            end
         end
      endcase
      r.occupancy = OCC_W'(held_count);
      r.is_full = (held_count == DEPTH);
      return r;
   endfunction

   task automatic send_item(op_type op, logic [VALUE_W-1:0] value, logic [TAG_W-1:0] tag);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {tag, value};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      awaited_replies.push_back(apply_stack_op(op, value, tag));
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_replies.size() != 0);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(bit from_stack);
      int roll;
      roll = $urandom_range(99);
      if (from_stack && held_count > 0 && roll < 50)
         return held_value[$urandom_range(held_count - 1)];
      else if (roll < 75)
         return VALUE_W'($signed($urandom_range(7)) - 4);
      else
         return $urandom();
   endfunction

   task automatic test_directed_edges();
      send_item(OP_POP, '0, '0);
      send_item(OP_FIND, '0, '0);
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_PUSH, 32'h8000_0000, 8'h00);
      send_item(OP_PUSH, 32'h7fff_ffff, 8'hff);
      send_item(OP_PUSH, 32'h0000_0000, 8'h55);
      send_item(OP_PUSH, 32'hffff_ffff, 8'haa);
      send_item(OP_PUSH, 32'd5, 8'h01);
      send_item(OP_PUSH, 32'd5, 8'h02);
      send_item(OP_PUSH, 32'd100, 8'h03);
      send_item(OP_PUSH, 32'd7, 8'h04);
      send_item(OP_PUSH, 32'd9, 8'h05);
      send_item(OP_FIND, 32'h8000_0000, 8'hff);
      send_item(OP_FIND, 32'd7, 8'h00);
      send_item(OP_FIND, 32'd5, 8'h00);
      send_item(OP_FIND, 32'd12345, 8'h00);
      send_item(OP_REMOVE, 32'd5, 8'h00);
      send_item(OP_REMOVE, 32'h8000_0000, 8'h00);
      send_item(OP_REMOVE, 32'd7, 8'h00);
      repeat (5) send_item(OP_POP, '0, '0);
      send_item(OP_POP, '0, '0);
      drain_replies();
   endtask

   // Traffic alternates between filling and emptying spells so that both the full and the
   // empty stack are reached often; find and remove keys come from the stack half the time to give hits.
   task automatic test_random_traffic(int n_items, int gap_pct, int stall_pct);
      bit filling;
      int roll;
      op_type op;
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      filling = 1'b1;
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(31) == 0) filling = ~filling;
         roll = $urandom_range(99);
         if (filling)
            op = roll < 55 ? OP_PUSH : roll < 65 ? OP_POP : roll < 82 ? OP_FIND : OP_REMOVE;
         else
            op = roll < 20 ? OP_PUSH : roll < 50 ? OP_POP : roll < 72 ? OP_FIND : OP_REMOVE;
         send_item(op, pick_value(op == OP_FIND || op == OP_REMOVE), TAG_W'($urandom_range(255)));
         if ($urandom_range(199) == 0) drain_replies();
      end
   endtask

   task automatic test_pause_until_drained();
      send_gap_pct = 0;
      rsp_stall_pct = 49;
      repeat (4) send_item(OP_PUSH, pick_value(1'b0), TAG_W'($urandom_range(255)));
      drain_replies();
      send_item(OP_FIND, pick_value(1'b1), '0);
      send_item(OP_REMOVE, pick_value(1'b1), '0);
      drain_replies();
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      stack_reply_type got;
      stack_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tuser);
         got.position = rsp_tdata[3:0];
         got.value = rsp_tdata[35:4];
         got.tag = rsp_tdata[43:36];
         got.occupancy = rsp_tdata[47:44];
         got.is_full = rsp_tdata[48];
         checked_count++;
         if (awaited_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("response %0d arrived with no item outstanding", checked_count);
         end else begin
            want = awaited_replies.pop_front();
            if (got !== want || rsp_tdata[55:49] !== '0) begin
               error_count++;
               if (error_count <= 10)
                  $display({"response %0d: expected status %0d pos %0d value %0d tag %0d ",
                            "occ %0d full %0d; got status %0d pos %0d value %0d tag %0d ",
                            "occ %0d full %0d pad %h"},
                           checked_count, want.status, want.position, $signed(want.value),
                           want.tag, want.occupancy, want.is_full, got.status, got.position,
                           $signed(got.value), got.tag, got.occupancy, got.is_full,
                           rsp_tdata[55:49]);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_random_traffic(PHASE_ITEMS, 0, 0);
      test_pause_until_drained();
      test_random_traffic(PHASE_ITEMS, 49, 0);
      test_random_traffic(PHASE_ITEMS, 0, 49);
      test_random_traffic(PHASE_ITEMS, 24, 24);
      drain_replies();
      repeat (MAX_LATENCY + 8) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
